// ===== hw/rtl/cp2rgb_pkg.sv =====
// Shared types, constants and arithmetic helpers for the camera pixel to RGB888 converter.
// It has no dependencies. Every other file in hw/rtl imports it.
`timescale 1ns / 1ps

package cp2rgb_pkg;

  // Input format codes held by the fmt_r register.
  typedef enum logic {
    FMT_RGB565 = 1'b0,
    FMT_YUYV   = 1'b1
  } pix_fmt_t;

  // Q16 chroma coefficients (1.772, 0.344, 0.714, 1.402).
  localparam logic [16:0] CB_B_COEF = 17'd116130;
  localparam logic [16:0] CB_G_COEF = 17'd22544;
  localparam logic [16:0] CR_G_COEF = 17'd46793;
  localparam logic [16:0] CR_R_COEF = 17'd91881;

  // Signed chroma terms. The largest magnitude is 226, so 9 bits hold them.
  typedef struct packed {
    logic signed [8:0] cb_b;
    logic signed [8:0] cb_g;
    logic signed [8:0] cr_g;
    logic signed [8:0] cr_r;
  } chroma_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Removes the 128 offset from a chroma byte, scales it by a Q16 coefficient
  // and truncates toward zero. The magnitude is at most 128, so the product
  // stays below 2^24.
  function automatic logic signed [8:0] q16_term(input logic [7:0] code,
                                                 input logic [16:0] coef);
    logic       neg;
    logic [7:0] mag;
    logic [24:0] prod;
    logic [8:0] p;
    neg  = ~code[7];
    mag  = neg ? (~{~code[7], code[6:0]} + 8'd1) : {1'b0, code[6:0]};
    prod = 25'(mag) * 25'(coef);
    p    = {1'b0, prod[23:16]};
    return neg ? -$signed(p) : $signed(p);
  endfunction

  // Clamps a signed sum to the 0..255 range of one channel.
  function automatic logic [7:0] clamp8(input logic signed [10:0] s);
    logic [7:0] res;
    if (s[10]) begin
      res = 8'd0;
    end else if (s[9:8] != 2'b00) begin
      res = 8'hFF;
    end else begin
      res = s[7:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/cp2rgb_chroma.sv =====
// Chroma term unit: scales the U and V bytes of one pixel pair by the Q16 coefficients.
// Depends on cp2rgb_pkg. Both pixels of a pair share its result.
`timescale 1ns / 1ps

module cp2rgb_chroma (
  input  logic [7:0]          u_byte,
  input  logic [7:0]          v_byte,
  output cp2rgb_pkg::chroma_t terms
);
  import cp2rgb_pkg::*;

  always_comb begin
    terms.cb_b = q16_term(u_byte, CB_B_COEF);
    terms.cb_g = q16_term(u_byte, CB_G_COEF);
    terms.cr_g = q16_term(v_byte, CR_G_COEF);
    terms.cr_r = q16_term(v_byte, CR_R_COEF);
  end

endmodule

// ===== hw/rtl/cp2rgb_pixel.sv =====
// Converts one pixel to RGB888, either by widening an RGB565 word or by adding
// chroma terms to its luma. Depends on cp2rgb_pkg.
`timescale 1ns / 1ps

module cp2rgb_pixel (
  input  cp2rgb_pkg::pix_fmt_t fmt,
  input  logic [7:0]           lo_byte,
  input  logic [7:0]           hi_byte,
  input  cp2rgb_pkg::chroma_t  terms,
  output cp2rgb_pkg::rgb_t     pixel
);
  import cp2rgb_pkg::*;

  logic [15:0]       word;
  logic [4:0]        r5;
  logic [5:0]        g6;
  logic [4:0]        b5;
  logic signed [10:0] y_ext;
  logic signed [10:0] sum_b;
  logic signed [10:0] sum_g;
  logic signed [10:0] sum_r;

  assign word  = {hi_byte, lo_byte};
  assign r5    = word[15:11];
  assign g6    = word[10:5];
  assign b5    = word[4:0];

  // In YUYV mode the low byte is the pixel's luma.
  assign y_ext = $signed({3'b000, lo_byte});
  assign sum_b = y_ext + {{2{terms.cb_b[8]}}, terms.cb_b};
  assign sum_g = y_ext - {{2{terms.cb_g[8]}}, terms.cb_g}
                       - {{2{terms.cr_g[8]}}, terms.cr_g};
  assign sum_r = y_ext + {{2{terms.cr_r[8]}}, terms.cr_r};

  always_comb begin
    case (fmt)
      FMT_RGB565: begin
        pixel.blue  = {b5, b5[4:2]};
        pixel.green = {g6, g6[5:4]};
        pixel.red   = {r5, r5[4:2]};
      end
      FMT_YUYV: begin
        pixel.blue  = clamp8(sum_b);
        pixel.green = clamp8(sum_g);
        pixel.red   = clamp8(sum_r);
      end
      default: begin
        pixel = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/camera_pixel_to_rgb888.sv =====
// Camera pixel-pair to RGB888 converter, top level. Depends on cp2rgb_pkg,
// cp2rgb_chroma and cp2rgb_pixel.
`timescale 1ns / 1ps

// The block accepts one request per clock while in_stall is low, each carrying
// four raw camera bytes that describe two pixels, and returns one result per
// request holding both pixels as 8-bit blue, green and red channels plus a
// copy of the end-of-frame flag. The cfg_wr_data bit selects the input format:
// 0 reads two little-endian RGB565 words, 1 reads YUYV 4:2:2 as Y0 U Y1 V. Write
// the format only while no request is in flight. A request passes through two
// register stages: an input register, then the conversion logic, then the
// result register. The sustained rate is one pixel pair per clock while the
// receiver does not stall. Those two stages also form the buffering between
// the sides: while a result waits on out_stall, one more request is still
// taken into the input register, and in_stall rises only when both stages
// are full and the result is not being taken.
module camera_pixel_to_rgb888 (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte0,
  input  logic [7:0] in_byte1,
  input  logic [7:0] in_byte2,
  input  logic [7:0] in_byte3,
  input  logic       in_end_of_frame,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_p0_blue,
  output logic [7:0] out_p0_green,
  output logic [7:0] out_p0_red,
  output logic [7:0] out_p1_blue,
  output logic [7:0] out_p1_green,
  output logic [7:0] out_p1_red,
  output logic       out_last_of_frame
);
  import cp2rgb_pkg::*;

  // Format register, written from the configuration port.
  pix_fmt_t   fmt_r;

  // Input register stage.
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_byte0_r;
  logic [7:0] s1_byte1_r;
  logic [7:0] s1_byte2_r;
  logic [7:0] s1_byte3_r;
  logic       s1_eof_r;

  // Result register stage.
  logic       out_valid_r;
  logic       out_valid_nxt;
  rgb_t       p0_r;
  rgb_t       p1_r;
  logic       out_eof_r;

  logic       in_take;
  logic       s1_adv;
  chroma_t    terms;
  rgb_t       p0_conv;
  rgb_t       p1_conv;

  // The result register can load when it is empty or its result is leaving.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  // The input register can load when it is empty or moving on this cycle.
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= FMT_RGB565;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fmt_r <= pix_fmt_t'(cfg_wr_data);
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; the valid bits qualify them.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte0_r <= in_byte0;
      s1_byte1_r <= in_byte1;
      s1_byte2_r <= in_byte2;
      s1_byte3_r <= in_byte3;
      s1_eof_r   <= in_end_of_frame;
    end
    if (s1_adv) begin
      p0_r      <= p0_conv;
      p1_r      <= p1_conv;
      out_eof_r <= s1_eof_r;
    end
  end

  // In YUYV mode byte1 is U and byte3 is V, shared by both pixels.
  cp2rgb_chroma u_chroma (
    .u_byte (s1_byte1_r),
    .v_byte (s1_byte3_r),
    .terms  (terms)
  );

  cp2rgb_pixel u_pix0 (
    .fmt     (fmt_r),
    .lo_byte (s1_byte0_r),
    .hi_byte (s1_byte1_r),
    .terms   (terms),
    .pixel   (p0_conv)
  );

  cp2rgb_pixel u_pix1 (
    .fmt     (fmt_r),
    .lo_byte (s1_byte2_r),
    .hi_byte (s1_byte3_r),
    .terms   (terms),
    .pixel   (p1_conv)
  );

  assign out_valid         = out_valid_r;
  assign out_p0_blue       = p0_r.blue;
  assign out_p0_green      = p0_r.green;
  assign out_p0_red        = p0_r.red;
  assign out_p1_blue       = p1_r.blue;
  assign out_p1_green      = p1_r.green;
  assign out_p1_red        = p1_r.red;
  assign out_last_of_frame = out_eof_r;

  // A request held behind a stalled result must not be dropped.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> s1_valid_r)
    else $error("input stage lost a request while the result was stalled");

  // A request that moves on shows up as a result carrying its frame flag.
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_valid_r && out_eof_r == $past(s1_eof_r)))
    else $error("result stage did not capture the advancing request");

  // An accepted request always lands in the input stage.
  a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted request did not reach the input stage");

  // Coming out of reset both stages are empty.
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");

endmodule

// ===== bench/camera_pixel_to_rgb888_checker.sv =====
// Scoreboard for the camera pixel to RGB888 converter: it watches the config
// port and both channels, predicts each result and compares it field by field.
// Depends on cp2rgb_pkg for the pixel format codes and the RGB channel struct.
`timescale 1ns / 1ps

module camera_pixel_to_rgb888_checker (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,

  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte0,
  input  logic [7:0] in_byte1,
  input  logic [7:0] in_byte2,
  input  logic [7:0] in_byte3,
  input  logic       in_end_of_frame,

  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_p0_blue,
  input  logic [7:0] out_p0_green,
  input  logic [7:0] out_p0_red,
  input  logic [7:0] out_p1_blue,
  input  logic [7:0] out_p1_green,
  input  logic [7:0] out_p1_red,
  input  logic       out_last_of_frame,

  output int         mismatches,
  output int         pairs_in,
  output int         pairs_out
);
  import cp2rgb_pkg::*;

  // BT.601 chroma weights in Q16.
  localparam int U_TO_BLUE  = 116130;
  localparam int U_TO_GREEN = 22544;
  localparam int V_TO_GREEN = 46793;
  localparam int V_TO_RED   = 91881;
  localparam int CHROMA_ZERO = 128;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    rgb_t px0;
    rgb_t px1;
    logic eof;
  } rgb_pair_t;

  rgb_pair_t expected_pairs[$];
  pix_fmt_t  cur_fmt;

  // Scales a signed chroma value and truncates toward zero.
  function automatic int chroma_scale(input int x, input int coef);
    int mag;
    int prod;
    mag  = (x < 0) ? -x : x;
    prod = (mag * coef) >>> 16;
    return (x < 0) ? -prod : prod;
  endfunction

  function automatic logic [7:0] saturate8(input int s);
    logic [7:0] res;
    if (s < 0) begin
      res = 8'd0;
    end else if (s > 255) begin
      res = 8'hFF;
    end else begin
      res = s[7:0];
    end
    return res;
  endfunction

  function automatic rgb_t widen_565(input logic [7:0] lo, input logic [7:0] hi);
    logic [15:0] word;
    logic [4:0]  r5;
    logic [5:0]  g6;
    logic [4:0]  b5;
    rgb_t        px;
    word     = {hi, lo};
    r5       = word[15:11];
    g6       = word[10:5];
    b5       = word[4:0];
    px.blue  = {b5, b5[4:2]};
    px.green = {g6, g6[5:4]};
    px.red   = {r5, r5[4:2]};
    return px;
  endfunction

  function automatic rgb_t yuv_pixel(input logic [7:0] luma, input int u, input int v);
    int   y;
    rgb_t px;
    y        = int'(luma);
    px.blue  = saturate8(y + chroma_scale(u, U_TO_BLUE));
    px.green = saturate8(y - chroma_scale(u, U_TO_GREEN) - chroma_scale(v, V_TO_GREEN));
    px.red   = saturate8(y + chroma_scale(v, V_TO_RED));
    return px;
  endfunction

  function automatic rgb_pair_t convert_pair(input pix_fmt_t fmt, input logic [7:0] b0,
                                             input logic [7:0] b1, input logic [7:0] b2,
                                             input logic [7:0] b3, input logic eof);
    rgb_pair_t pair;
    int        u;
    int        v;
    if (fmt == FMT_RGB565) begin
      pair.px0 = widen_565(b0, b1);
      pair.px1 = widen_565(b2, b3);
    end else begin
      u        = int'(b1) - CHROMA_ZERO;
      v        = int'(b3) - CHROMA_ZERO;
      pair.px0 = yuv_pixel(b0, u, v);
      pair.px1 = yuv_pixel(b2, u, v);
    end
    pair.eof = eof;
    return pair;
  endfunction

  function automatic string field_label(input int idx);
    string lbl;
    case (idx)
      0: lbl = "p0_blue";
      1: lbl = "p0_green";
      2: lbl = "p0_red";
      3: lbl = "p1_blue";
      4: lbl = "p1_green";
      5: lbl = "p1_red";
      default: lbl = "last_of_frame";
    endcase
    return lbl;
  endfunction

  always @(posedge clk) begin : watch
    rgb_pair_t want;
    int        want_v[7];
    int        got_v[7];
    int        errs;
    errs = 0;
    if (!rst_n) begin
      cur_fmt = FMT_RGB565;
      expected_pairs.delete();
      mismatches <= 0;
      pairs_in   <= 0;
      pairs_out  <= 0;
    end else begin
      // A request taken at this edge sees the format from before any write here.
      if (in_valid && !in_stall) begin
        expected_pairs.push_back(convert_pair(cur_fmt, in_byte0, in_byte1, in_byte2,
                                              in_byte3, in_end_of_frame));
        pairs_in <= pairs_in + 1;
      end
      if (out_valid && !out_stall) begin
        pairs_out <= pairs_out + 1;
        if (expected_pairs.size() == 0) begin
          errs = 1;
          if (mismatches < REPORT_MAX) begin
            $display("[%0t] result with no request outstanding", $realtime);
          end
        end else begin
          want   = expected_pairs.pop_front();
          want_v = '{want.px0.blue, want.px0.green, want.px0.red,
                     want.px1.blue, want.px1.green, want.px1.red, want.eof};
          got_v  = '{out_p0_blue, out_p0_green, out_p0_red,
                     out_p1_blue, out_p1_green, out_p1_red, out_last_of_frame};
          for (int i = 0; i < 7; i++) begin
            if (want_v[i] != got_v[i]) begin
              if (mismatches + errs < REPORT_MAX) begin
                $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime,
                         field_label(i), want_v[i], got_v[i]);
              end
              errs++;
            end
          end
        end
      end
      if (errs != 0) begin
        mismatches <= mismatches + errs;
      end
      if (cfg_wr_en) begin
        cur_fmt = pix_fmt_t'(cfg_wr_data);
      end
    end
  end

endmodule

// ===== bench/tb_camera_pixel_to_rgb888.sv =====
// Testbench top for the camera pixel to RGB888 converter: clock, reset, stimulus,
// output back-pressure and the final verdict. Depends on cp2rgb_pkg, the block
// and camera_pixel_to_rgb888_checker.
`timescale 1ns / 1ps

module tb_camera_pixel_to_rgb888;
  import cp2rgb_pkg::*;

  // The slowest legal run is 1514 requests, each waiting out a long
  // stall streak and a sender gap; this limit leaves an order of magnitude spare.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 250;
  // Two register stages in the block; the settle wait after a drain covers them.
  localparam int SETTLE_CYCLES = 6;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;

  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte0 = 8'd0;
  logic [7:0] in_byte1 = 8'd0;
  logic [7:0] in_byte2 = 8'd0;
  logic [7:0] in_byte3 = 8'd0;
  logic       in_end_of_frame = 1'b0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_p0_blue;
  logic [7:0] out_p0_green;
  logic [7:0] out_p0_red;
  logic [7:0] out_p1_blue;
  logic [7:0] out_p1_green;
  logic [7:0] out_p1_red;
  logic       out_last_of_frame;

  int mismatches;
  int pairs_in;
  int pairs_out;
  int cycle_count = 0;
  int format_writes = 0;
  int burst_left = 0;

  // Receiver back-pressure state: a stall style held for a random stretch.
  int stall_style = 0;
  int style_left = 0;

  always #1 clk = ~clk;

  camera_pixel_to_rgb888 u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte0          (in_byte0),
    .in_byte1          (in_byte1),
    .in_byte2          (in_byte2),
    .in_byte3          (in_byte3),
    .in_end_of_frame   (in_end_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_p0_blue       (out_p0_blue),
    .out_p0_green      (out_p0_green),
    .out_p0_red        (out_p0_red),
    .out_p1_blue       (out_p1_blue),
    .out_p1_green      (out_p1_green),
    .out_p1_red        (out_p1_red),
    .out_last_of_frame (out_last_of_frame)
  );

  camera_pixel_to_rgb888_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte0          (in_byte0),
    .in_byte1          (in_byte1),
    .in_byte2          (in_byte2),
    .in_byte3          (in_byte3),
    .in_end_of_frame   (in_end_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_p0_blue       (out_p0_blue),
    .out_p0_green      (out_p0_green),
    .out_p0_red        (out_p0_red),
    .out_p1_blue       (out_p1_blue),
    .out_p1_green      (out_p1_green),
    .out_p1_red        (out_p1_red),
    .out_last_of_frame (out_last_of_frame),
    .mismatches        (mismatches),
    .pairs_in          (pairs_in),
    .pairs_out         (pairs_out)
  );

  // Watchdog. A hung handshake ends the run here instead of spinning forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiver switches between a few stall styles: never stalling, light
  // random stalls, heavy random stalls and a regular on/off beat. Each style is
  // held for a random stretch, so stalls land on every phase of the pipeline and
  // there are also long clean stretches where the block must run at full rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style <= $urandom_range(0, 3);
        style_left  <= $urandom_range(20, 200);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 25);
        2: out_stall <= ($urandom_range(0, 99) < 75);
        default: out_stall <= style_left[2];
      endcase
    end
  end

  // Presents one request and holds it until the block takes it. The sender
  // works in bursts: when a burst runs out, valid drops for a random gap (which
  // may be zero) and a new burst length is drawn. Occasionally a very long
  // burst is drawn so that the input runs back to back for a while. Valid is
  // only ever raised here and only lowered at a gap or when draining,
  // so it never gets two assignments in the same time step.
  task automatic send_request(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3,
                              input logic eof);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(1, 40);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_byte0        <= b0;
    in_byte1        <= b1;
    in_byte2        <= b2;
    in_byte3        <= b3;
    in_end_of_frame <= eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops sending and waits until every request has come back as a result.
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pairs_out != pairs_in);
  endtask

  // The format may only change while nothing is in flight. After the last
  // result arrives we wait out SETTLE_CYCLES before writing.
  task automatic write_format(input pix_fmt_t fmt);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= fmt;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    format_writes++;
  endtask

  // Uniform random bytes exercise every bit; the end-of-frame flag is set on
  // roughly one request in sixteen, as at the end of short lines of pixels.
  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   ($urandom_range(0, 15) == 0));
    end
  endtask

  initial begin
    pix_fmt_t phase_fmt;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed RGB565 requests in the reset format: all zero, all ones, each
    // channel alone at full scale, alternating bit patterns, and a frame end.
    send_request(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0);
    send_request(8'h00, 8'hF8, 8'hE0, 8'h07, 1'b0);
    send_request(8'h1F, 8'h00, 8'h55, 8'h55, 1'b0);
    send_request(8'hAA, 8'hAA, 8'h21, 8'h08, 1'b0);
    send_request(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1);

    // Directed YUYV requests. Chroma bytes of 0 and 255 give the most negative
    // and most positive offsets, 128 gives zero chroma, and 127 and 129 give
    // offsets of minus and plus one, where truncation toward zero matters.
    // Luma at 0 and 255 with strong chroma drives every channel into both the
    // low and the high clamp.
    write_format(FMT_YUYV);
    send_request(8'h00, 8'h00, 8'hFF, 8'h00, 1'b0);
    send_request(8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b0);
    send_request(8'h80, 8'h80, 8'h80, 8'h80, 1'b0);
    send_request(8'h00, 8'h7F, 8'hFF, 8'h81, 1'b0);
    send_request(8'h00, 8'h81, 8'hFF, 8'h7F, 1'b0);
    send_request(8'h10, 8'h00, 8'hEB, 8'hFF, 1'b0);
    send_request(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1);
    send_request(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0);
    send_request(8'h40, 8'h20, 8'hC0, 8'hE0, 1'b1);

    // Random phases alternate the format, starting with a rewrite of the
    // current one, so every phase begins with a write of the register.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      phase_fmt = (p % 2 == 0) ? FMT_YUYV : FMT_RGB565;
      write_format(phase_fmt);
      send_random(PHASE_ITEMS);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d of %0d pixel pairs over %0d format writes (RGB565 and YUYV),",
             pairs_out, pairs_in, format_writes);
    $display("with random sender bursts and receiver stalls; %0d field mismatches.",
             mismatches);
    if (mismatches == 0 && pairs_out == pairs_in) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cp2rgb_pkg.sv
hw/rtl/cp2rgb_chroma.sv
hw/rtl/cp2rgb_pixel.sv
hw/rtl/camera_pixel_to_rgb888.sv
bench/camera_pixel_to_rgb888_checker.sv
bench/tb_camera_pixel_to_rgb888.sv
